>>> hw/rtl/hssq_pkg.sv
// ----------------------------------------------------------------------------
// hssq_pkg - shared types and constants of the half-step sequencer
// Coil table, event codes, register addresses and the structs that pass
// between the step logic, the result queue and the top level.
// ----------------------------------------------------------------------------
package hssq_pkg;

  localparam int PHASE_W = 3;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 16;
  localparam int OVER_W  = 13;
  localparam int COIL_W  = 4;
  localparam int EVENT_W = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // half-step coil drive table, phase 0 first
  localparam logic [COIL_W-1:0] COIL_TABLE [8] = '{
    4'd2, 4'd6, 4'd4, 4'd5, 4'd1, 4'd9, 4'd8, 4'd10
  };

  localparam logic [LIMIT_W-1:0] TRAVEL_LIMIT_RESET  = 16'd1376;
  localparam logic [OVER_W-1:0]  OVERRUN_STEPS_RESET = 13'd160;

  localparam logic [ADDR_W-1:0] ADDR_TRAVEL_LIMIT  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_OVERRUN_STEPS = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE        = 2'd0;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT     = 2'd1;
  localparam logic [EVENT_W-1:0] EV_OPEN_DONE   = 2'd2;
  localparam logic [EVENT_W-1:0] EV_CLOSE_DONE  = 2'd3;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic MOVE_OPEN  = 1'b0;
  localparam logic MOVE_CLOSE = 1'b1;

  localparam logic [1:0] SW_OPEN  = 2'd1;
  localparam logic [1:0] SW_CLOSE = 2'd2;
  localparam logic [1:0] SW_BOTH  = 2'd3;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_index;
    logic [COUNT_W-1:0] step_count;
    logic               move_direction;
    logic               active;
    logic [COIL_W-1:0]  coil_register;
    logic               enable_register;
  } motor_state_t;

  // one result item; the low eight bits form tdata, last goes to tlast
  typedef struct packed {
    logic               last;
    logic               running;
    logic [EVENT_W-1:0] event_code;
    logic               coil_enable;
    logic [COIL_W-1:0]  coil_pattern;
  } result_t;

  typedef struct packed {
    motor_state_t state_next;
    result_t      res0;
    result_t      res1;
    logic         two;
  } step_out_t;

endpackage

>>> hw/rtl/hssq_step.sv
// ----------------------------------------------------------------------------
// hssq_step - next-state and result logic for one input item
// Table lookup, phase advance, step counting and stop decisions.
// ----------------------------------------------------------------------------
module hssq_step #(
  parameter int PHASE_COUNT = 8
) (
  input  hssq_pkg::motor_state_t           cur,
  input  logic                             kind,
  input  logic                             direction,
  input  logic [1:0]                       limit_switches,
  input  logic [hssq_pkg::LIMIT_W-1:0]     travel_limit,
  input  logic [hssq_pkg::OVER_W-1:0]      overrun_steps,
  output hssq_pkg::step_out_t              out
);
  import hssq_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);

  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  phase_next;
  logic [COIL_W-1:0]   coil_now;
  logic                sw_hit;
  logic                below;
  logic                timeout;
  logic [COUNT_W-1:0]  base;
  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W:0]    bound;
  logic                over_stop;
  logic [EVENT_W-1:0]  fin_code;

  always_comb begin
    // wrap a stale index that lies beyond the table in use
    phase    = (cur.phase_index > PHASE_LAST) ? '0 : cur.phase_index;
    coil_now = COIL_TABLE[phase];
    if (cur.move_direction == MOVE_OPEN) begin
      phase_next = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
    end else begin
      phase_next = (phase == '0) ? PHASE_LAST : phase - 1'b1;
    end
    fin_code = (cur.move_direction == MOVE_OPEN) ? EV_OPEN_DONE : EV_CLOSE_DONE;

    sw_hit = (cur.move_direction == MOVE_OPEN  && limit_switches == SW_OPEN) ||
             (cur.move_direction == MOVE_CLOSE && limit_switches == SW_CLOSE) ||
             (limit_switches == SW_BOTH);
    below   = cur.step_count < travel_limit;
    timeout = cur.step_count == travel_limit;
    // jump past the travel limit so that only the overrun remains
    base      = (below && sw_hit) ? travel_limit + 1'b1 : cur.step_count;
    count_inc = base + 1'b1;
    bound     = {1'b0, travel_limit} + {{(COUNT_W + 1 - OVER_W){1'b0}}, overrun_steps};
    over_stop = {1'b0, count_inc} >= bound;

    out.state_next = cur;
    out.two        = 1'b0;
    out.res1       = '{last: 1'b1, running: 1'b0, event_code: fin_code,
                       coil_enable: 1'b0, coil_pattern: '0};
    out.res0       = '{last: 1'b1, running: 1'b0, event_code: EV_NONE,
                       coil_enable: cur.enable_register,
                       coil_pattern: cur.coil_register};

    if (kind == KIND_START) begin
      out.state_next.step_count      = '0;
      out.state_next.move_direction  = direction;
      out.state_next.enable_register = 1'b1;
      out.state_next.active          = 1'b1;
      out.res0.coil_enable           = 1'b1;
      out.res0.running               = 1'b1;
    end else if (cur.active) begin
      out.state_next.phase_index = phase_next;
      if (timeout) begin
        out.state_next.coil_register   = '0;
        out.state_next.enable_register = 1'b0;
        out.state_next.active          = 1'b0;
        out.res0 = '{last: 1'b0, running: 1'b0, event_code: EV_TIMEOUT,
                     coil_enable: cur.enable_register, coil_pattern: coil_now};
        out.two  = 1'b1;
      end else if (over_stop) begin
        out.state_next.step_count      = count_inc;
        out.state_next.coil_register   = '0;
        out.state_next.enable_register = 1'b0;
        out.state_next.active          = 1'b0;
        out.res0 = out.res1;
      end else begin
        out.state_next.step_count    = count_inc;
        out.state_next.coil_register = coil_now;
        out.res0.coil_pattern        = coil_now;
        out.res0.running             = 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/hssq_out_queue.sv
// ----------------------------------------------------------------------------
// hssq_out_queue - four-entry result queue
// Takes up to two result items a cycle and hands out one; room stays high
// while at least two entries are free, also while the output side stalls.
// ----------------------------------------------------------------------------
module hssq_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                push_two,
  input  hssq_pkg::result_t   din0,
  input  hssq_pkg::result_t   din1,
  output logic                room,
  output logic                valid,
  input  logic                pop,
  output hssq_pkg::result_t   dout
);
  import hssq_pkg::*;

  result_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [1:0] wr_ptr_b;
  logic       do_pop;
  logic [1:0] n_push;

  always_comb begin
    do_pop     = pop && valid;
    n_push     = push ? (push_two ? 2'd2 : 2'd1) : 2'd0;
    count_next = count + {1'b0, n_push} - {2'b0, do_pop};
    wr_ptr_b   = wr_ptr + 1'b1;
  end

  assign room  = count <= 3'd2;
  assign valid = count != '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din0;
      if (push_two) begin
        entries[wr_ptr_b] <= din1;
      end
    end
  end

endmodule

>>> hw/rtl/half_step_stepper_sequencer_unit.sv
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_unit - half-step sequencer for a two-coil motor
//
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   s_tuser kind, s_tdata direction, switches
//  m_*       out  m_tvalid/tready   m_tdata coil, enable, event, running; tlast
//  apb       in   psel/penable      travel_limit @0x0, overrun_steps @0x4
//
//  An item's results enter a four-entry queue at the edge that accepts it,
//  and the first can leave on the next cycle.
//  A timeout item yields two results; the queue sets the rate when m_tready
//  stays low, s_tready drops once fewer than two entries are free.
//  Synchronous reset clears motor state and queue pointers and loads the registers with their reset values.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer_unit #(
  parameter int PHASE_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [0] direction, [2:1] limit_switches
  input  logic                          s_tuser,  // [0] kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // [3:0] coil_pattern, [4] coil_enable,
                                                  // [6:5] event_code, [7] running
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hssq_pkg::ADDR_W-1:0]   paddr,
  input  logic [hssq_pkg::DATA_W-1:0]   pwdata,
  output logic [hssq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import hssq_pkg::*;

  motor_state_t        motor;
  step_out_t           step;
  logic [LIMIT_W-1:0]  travel_limit;
  logic [OVER_W-1:0]   overrun_steps;
  logic                accept;
  logic                cfg_wr;
  result_t             head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    case (paddr)
      ADDR_TRAVEL_LIMIT:  prdata = {{(DATA_W - LIMIT_W){1'b0}}, travel_limit};
      ADDR_OVERRUN_STEPS: prdata = {{(DATA_W - OVER_W){1'b0}}, overrun_steps};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_limit  <= TRAVEL_LIMIT_RESET;
      overrun_steps <= OVERRUN_STEPS_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_TRAVEL_LIMIT:  travel_limit  <= pwdata[LIMIT_W-1:0];
        ADDR_OVERRUN_STEPS: overrun_steps <= pwdata[OVER_W-1:0];
        default: ;
      endcase
    end
  end

  hssq_step #(
    .PHASE_COUNT (PHASE_COUNT)
  ) u_step (
    .cur            (motor),
    .kind           (s_tuser),
    .direction      (s_tdata[0]),
    .limit_switches (s_tdata[2:1]),
    .travel_limit   (travel_limit),
    .overrun_steps  (overrun_steps),
    .out            (step)
  );

  // advance motor state on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      motor <= '0;
    end else if (accept) begin
      motor <= step.state_next;
    end
  end

  hssq_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_two (step.two),
    .din0     (step.res0),
    .din1     (step.res1),
    .room     (s_tready),
    .valid    (m_tvalid),
    .pop      (m_tready),
    .dout     (head)
  );

  assign m_tdata = {head.running, head.event_code, head.coil_enable, head.coil_pattern};
  assign m_tlast = head.last;

endmodule
